/* rtl/quota_fifo_credit_drain_core_defines.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef QUOTA_FIFO_CREDIT_DRAIN_CORE_DEFINES_SVH
`define QUOTA_FIFO_CREDIT_DRAIN_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QFCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QFCD_ASSERT(lbl, prop, msg)
`define QFCD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/qfcd_pkg.sv */
package qfcd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int USER_COUNT  = 256;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int UA_W        = $clog2(USER_COUNT);
  localparam int PEND_W      = 4;
  localparam logic [PEND_W-1:0] LIMIT_RESET = PEND_W'(3);

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_PRINT  = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_USER_LIMIT = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_PRINTED    = 3'd3,
    ST_FINISHED   = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  user;
    logic [15:0] tag;
    logic [11:0] pages;
  } job_t;

  function automatic logic [UA_W-1:0] user_index(input logic [7:0] u);
    return UA_W'(32'(u) % USER_COUNT);
  endfunction

  function automatic logic [QA_W-1:0] next_slot(input logic [QA_W-1:0] p);
    if (p == QA_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return QA_W'(p + QA_W'(1));
    end
  endfunction

endpackage

/* rtl/qfcd_ram.sv */
module qfcd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/quota_fifo_credit_drain_core.sv */
// Channel   | Handshake           | Word
// ----------+---------------------+---------------------------------------------
// command   | start / busy        | command, user_id, job_tag, pages, paper
// result    | result_valid        | status, out_user, out_tag, out_pages,
//           |                     | paper_left, last
// config    | cfg_we              | cfg_data (user limit)
//
// A command is taken when start is high and busy is low.
// A submit reads the user's quota count, then writes the raised count back if accepted.
// A print of an empty queue answers in the cycle after it is taken; otherwise each
// printed job passes a job memory read, then a quota memory update, and the
// finish word follows in the cycle after the last one.
// After reset, busy stays high while the quota memory is cleared.
// Result words last one cycle each and cannot be held off by the receiver.
`include "quota_fifo_credit_drain_core_defines.svh"

module quota_fifo_credit_drain_core import qfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  user_id,
  input  logic [15:0] job_tag,
  input  logic [11:0] pages,
  input  logic [15:0] paper,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [7:0]  out_user,
  output logic [15:0] out_tag,
  output logic [11:0] out_pages,
  output logic [15:0] paper_left,
  output logic        last
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUB,
    S_PHEAD,
    S_PUSR,
    S_FIN
  } state_t;

  state_t              state;
  logic [UA_W-1:0]     clr_addr;
  logic [QA_W-1:0]     head_ptr;
  logic [QA_W-1:0]     tail_ptr;
  logic [OCC_W-1:0]    occ;
  logic [PEND_W-1:0]   user_limit;
  job_t                lat_job;
  job_t                job_r;
  logic [15:0]         budget;
  status_t             status_r;

  logic                job_we;
  logic [QA_W-1:0]     job_addr;
  job_t                job_wdata;
  job_t                job_rdata;
  logic                usr_we;
  logic [UA_W-1:0]     usr_addr;
  logic [PEND_W-1:0]   usr_wdata;
  logic [PEND_W-1:0]   usr_rdata;
  logic                fits;
  logic                full;

  assign busy   = (state != S_IDLE);
  assign status = status_r;
  assign fits   = ({4'd0, job_rdata.pages} <= budget);
  assign full   = (occ == OCC_W'(QUEUE_DEPTH));

  qfcd_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(job_t))) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .addr  (job_addr),
    .wdata (job_wdata),
    .rdata (job_rdata)
  );

  qfcd_ram #(.DEPTH(USER_COUNT), .WIDTH(PEND_W)) u_quota_ram (
    .clk   (clk),
    .we    (usr_we),
    .addr  (usr_addr),
    .wdata (usr_wdata),
    .rdata (usr_rdata)
  );

  always_comb begin
    job_we    = 1'b0;
    job_addr  = head_ptr;
    job_wdata = lat_job;
    usr_we    = 1'b0;
    usr_addr  = user_index(lat_job.user);
    usr_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        usr_we   = 1'b1;
        usr_addr = clr_addr;
      end
      S_IDLE: begin
        usr_addr = user_index(user_id);
      end
      S_SUB: begin
        if ((usr_rdata < user_limit) && !full) begin
          job_we    = 1'b1;
          job_addr  = tail_ptr;
          usr_we    = 1'b1;
          usr_wdata = PEND_W'(usr_rdata + PEND_W'(1));
        end
      end
      S_PHEAD: begin
        usr_addr = user_index(job_rdata.user);
      end
      S_PUSR: begin
        usr_addr  = user_index(job_r.user);
        usr_we    = (usr_rdata != '0);
        usr_wdata = PEND_W'(usr_rdata - PEND_W'(1));
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      occ        <= '0;
      user_limit <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        user_limit <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= UA_W'(clr_addr + UA_W'(1));
          if (clr_addr == UA_W'(USER_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            lat_job <= '{user: user_id, tag: job_tag, pages: pages};
            budget  <= paper;
            if (command == CMD_SUBMIT) begin
              state <= S_SUB;
            end else if (occ == '0) begin
              result_valid <= 1'b1;
              status_r     <= ST_EMPTY;
              out_user     <= '0;
              out_tag      <= '0;
              out_pages    <= '0;
              paper_left   <= paper;
              last         <= 1'b1;
            end else begin
              state <= S_PHEAD;
            end
          end
        end
        S_SUB: begin
          result_valid <= 1'b1;
          out_user     <= lat_job.user;
          out_tag      <= lat_job.tag;
          out_pages    <= lat_job.pages;
          paper_left   <= '0;
          last         <= 1'b1;
          if (usr_rdata >= user_limit) begin
            status_r <= ST_USER_LIMIT;
          end else if (full) begin
            status_r <= ST_QUEUE_FULL;
          end else begin
            status_r <= ST_ACCEPTED;
            tail_ptr <= next_slot(tail_ptr);
            occ      <= OCC_W'(occ + OCC_W'(1));
          end
          state <= S_IDLE;
        end
        S_PHEAD: begin
          if (fits) begin
            job_r    <= job_rdata;
            budget   <= budget - {4'd0, job_rdata.pages};
            head_ptr <= next_slot(head_ptr);
            occ      <= OCC_W'(occ - OCC_W'(1));
            state    <= S_PUSR;
          end else begin
            result_valid <= 1'b1;
            status_r     <= ST_FINISHED;
            out_user     <= '0;
            out_tag      <= '0;
            out_pages    <= '0;
            paper_left   <= budget;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_PUSR: begin
          result_valid <= 1'b1;
          status_r     <= ST_PRINTED;
          out_user     <= job_r.user;
          out_tag      <= job_r.tag;
          out_pages    <= job_r.pages;
          paper_left   <= budget;
          last         <= 1'b0;
          if (occ != '0) begin
            state <= S_PHEAD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          result_valid <= 1'b1;
          status_r     <= ST_FINISHED;
          out_user     <= '0;
          out_tag      <= '0;
          out_pages    <= '0;
          paper_left   <= budget;
          last         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QFCD_ASSERT(a_occ_bound, occ <= OCC_W'(QUEUE_DEPTH), "Occupancy exceeds queue depth.")
  `QFCD_ASSERT(a_mid_is_printed, result_valid && !last |-> status == ST_PRINTED, "Non-final word is not a printed job.")
  `QFCD_ASSERT(a_empty_reply, start && !busy && command == CMD_PRINT && occ == '0 |=> result_valid && status == ST_EMPTY, "Print of an empty queue gave no empty status.")
  `QFCD_ASSERT_RST(a_clear_after_reset, rst |=> busy, "Block not busy after reset.")

endmodule
